/* rtl/sat_pkg.sv */
`timescale 1ns / 1ps
// section address translation table: shared types and codes
// no dependencies; used by the interfaces and the top level

package sat_pkg;

	localparam int ADDR_W = 64;
	localparam int PERM_W = 3;

	// action codes carried in the request item
	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_V2O    = 3'd2,
		ACT_O2V    = 3'd3,
		ACT_LOOKUP = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CMP,
		ST_FIN,
		ST_MV_RD,
		ST_MV_WR,
		ST_DONE
	} state_t;

	// one table entry as stored in the ram
	typedef struct packed {
		logic [ADDR_W-1:0] off;
		logic [ADDR_W-1:0] va;
		logic [ADDR_W-1:0] fsize;
		logic [ADDR_W-1:0] vsize;
		logic [PERM_W-1:0] perms;
	} entry_t;

	localparam logic [ADDR_W-1:0] ALL_ONES  = '1;
	localparam logic [PERM_W-1:0] PERM_NONE = '1;

endpackage

/* rtl/sat_if.sv */
`timescale 1ns / 1ps
// request and response channels of the translation table
// depends on sat_pkg for field widths

interface sat_in_if;
	logic                         valid;
	logic                         ready;
	logic [2:0]                   action;
	logic [sat_pkg::ADDR_W-1:0]   file_offset;
	logic [sat_pkg::ADDR_W-1:0]   virt_addr;
	logic [sat_pkg::ADDR_W-1:0]   region_size;
	logic [sat_pkg::ADDR_W-1:0]   virt_size;
	logic [sat_pkg::PERM_W-1:0]   perms;
	logic [3:0]                   entry_index;

	modport source (
		output valid, action, file_offset, virt_addr, region_size, virt_size,
			perms, entry_index,
		input  ready
	);
	modport sink (
		input  valid, action, file_offset, virt_addr, region_size, virt_size,
			perms, entry_index,
		output ready
	);
endinterface

interface sat_out_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [sat_pkg::ADDR_W-1:0]   result_addr;
	logic [sat_pkg::ADDR_W-1:0]   found_offset;
	logic [sat_pkg::ADDR_W-1:0]   found_vaddr;
	logic [sat_pkg::PERM_W-1:0]   found_perms;

	modport source (
		output valid, status, result_addr, found_offset, found_vaddr, found_perms,
		input  ready
	);
	modport sink (
		input  valid, status, result_addr, found_offset, found_vaddr, found_perms,
		output ready
	);
endinterface

/* rtl/sat_ram.sv */
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
// no dependencies

module sat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/section_address_translation_table_top.sv */
`timescale 1ns / 1ps
// Section translation table: an add goes straight to done; a remove with a good index
// shifts later entries down by read and write states; a translation or lookup scans
// entries by evaluate and compare. One item is in work at a time; the next is taken
// once the result sits in the output register. The scan rate is set by the single ram
// read port and the one 64-bit adder/comparer pair that every entry passes through.
// Reset clears the entry count and the sequencer; table contents stay undefined.

module section_address_translation_table_top #(
	parameter int MAX_SECTIONS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	sat_in_if.sink    req,
	sat_out_if.source rsp
);

	localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);
	localparam int XW = (CW > 4) ? CW : 4;
	localparam int EW = $bits(sat_pkg::entry_t);

	sat_pkg::state_t  state_q, state_nxt;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    ptr_step;
	logic             out_valid_q;

	sat_pkg::action_t act_in, act_q;
	logic [sat_pkg::ADDR_W-1:0] q_q;
	sat_pkg::entry_t  ent_q;
	logic [sat_pkg::ADDR_W-1:0] diff_q, lim_q;
	logic             ge_q;

	// staged result of the item in work
	sat_pkg::status_t           res_status_q;
	logic [sat_pkg::ADDR_W-1:0] res_addr_q, res_foff_q, res_fva_q;
	logic [sat_pkg::PERM_W-1:0] res_fperm_q;

	// output register
	logic [1:0]                 out_status_q;
	logic [sat_pkg::ADDR_W-1:0] out_addr_q, out_foff_q, out_fva_q;
	logic [sat_pkg::PERM_W-1:0] out_fperm_q;

	logic             req_fire, is_lookup, is_v2o, full, idx_ok, more, last, hit, load_out;
	logic             wr_en;
	logic [IW-1:0]    wr_addr, rd_addr;
	sat_pkg::entry_t  wr_ent, rd_ent;
	logic [EW-1:0]    rd_data;
	logic [sat_pkg::ADDR_W-1:0] base, size;
	logic [sat_pkg::ADDR_W:0]   diff_w;

	sat_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_SECTIONS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (EW'(wr_ent)),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_ent = sat_pkg::entry_t'(rd_data);

	// decode and loop conditions
	assign act_in    = sat_pkg::action_t'(req.action);
	assign req_fire  = req.valid && req.ready;
	assign is_lookup = (act_q == sat_pkg::ACT_LOOKUP);
	assign is_v2o    = (act_q == sat_pkg::ACT_V2O);
	assign full      = (count_q == CW'(MAX_SECTIONS));
	assign idx_ok    = (XW'(req.entry_index) < XW'(count_q));
	assign more      = (({1'b0, ptr_q} + (CW+1)'(1)) < {1'b0, count_q});
	assign last      = is_lookup ? (ptr_q == '0)
		: (({1'b0, ptr_q} + (CW+1)'(1)) == {1'b0, count_q});
	assign hit       = ge_q && (is_lookup ? (q_q <= lim_q) : (q_q < lim_q));
	assign ptr_step  = is_lookup ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));
	assign load_out  = !out_valid_q || rsp.ready;

	// shared adder and comparer operands
	assign base   = is_v2o ? rd_ent.va : rd_ent.off;
	assign size   = is_v2o ? rd_ent.vsize : rd_ent.fsize;
	assign diff_w = {1'b0, q_q} - {1'b0, base};

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sat_pkg::ST_IDLE: begin
				if (req.valid) begin
					unique case (act_in)
						sat_pkg::ACT_ADD:    state_nxt = sat_pkg::ST_DONE;
						sat_pkg::ACT_REMOVE: state_nxt = idx_ok ? sat_pkg::ST_MV_RD
							: sat_pkg::ST_DONE;
						sat_pkg::ACT_V2O,
						sat_pkg::ACT_O2V,
						sat_pkg::ACT_LOOKUP: state_nxt = (count_q == '0) ? sat_pkg::ST_DONE
							: sat_pkg::ST_EVAL;
						default:             state_nxt = sat_pkg::ST_DONE;
					endcase
				end
			end
			sat_pkg::ST_EVAL: state_nxt = sat_pkg::ST_CMP;
			sat_pkg::ST_CMP: begin
				if (hit) begin
					state_nxt = is_lookup ? sat_pkg::ST_DONE : sat_pkg::ST_FIN;
				end else if (last) begin
					state_nxt = sat_pkg::ST_DONE;
				end else begin
					state_nxt = sat_pkg::ST_EVAL;
				end
			end
			sat_pkg::ST_FIN:   state_nxt = sat_pkg::ST_DONE;
			sat_pkg::ST_MV_RD: state_nxt = more ? sat_pkg::ST_MV_WR : sat_pkg::ST_DONE;
			sat_pkg::ST_MV_WR: state_nxt = sat_pkg::ST_MV_RD;
			sat_pkg::ST_DONE:  state_nxt = load_out ? sat_pkg::ST_IDLE : sat_pkg::ST_DONE;
			default:           state_nxt = sat_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and ram ports
	always_comb begin
		req.ready = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = ptr_q[IW-1:0];
		wr_ent    = rd_ent;
		rd_addr   = ptr_q[IW-1:0];
		unique case (state_q)
			sat_pkg::ST_IDLE: begin
				req.ready    = 1'b1;
				wr_en        = req.valid && (act_in == sat_pkg::ACT_ADD) && !full;
				wr_addr      = count_q[IW-1:0];
				wr_ent.off   = req.file_offset;
				wr_ent.va    = req.virt_addr;
				wr_ent.fsize = req.region_size;
				wr_ent.vsize = req.virt_size;
				wr_ent.perms = req.perms;
				rd_addr      = (act_in == sat_pkg::ACT_LOOKUP)
					? IW'(count_q - CW'(1)) : '0;
			end
			sat_pkg::ST_CMP:   rd_addr = ptr_step[IW-1:0];
			sat_pkg::ST_MV_RD: rd_addr = IW'(ptr_q + CW'(1));
			sat_pkg::ST_MV_WR: wr_en = 1'b1;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sat_pkg::ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				sat_pkg::ST_IDLE: begin
					if (req_fire) begin
						if (act_in == sat_pkg::ACT_LOOKUP) begin
							ptr_q <= count_q - CW'(1);
						end else if (act_in == sat_pkg::ACT_REMOVE) begin
							ptr_q <= CW'(req.entry_index);
						end else begin
							ptr_q <= '0;
						end
						if (act_in == sat_pkg::ACT_ADD && !full) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				sat_pkg::ST_CMP: begin
					if (!hit && !last) begin
						ptr_q <= ptr_step;
					end
				end
				sat_pkg::ST_MV_RD: begin
					if (!more) begin
						count_q <= count_q - CW'(1);
					end
				end
				sat_pkg::ST_MV_WR: ptr_q <= ptr_q + CW'(1);
				default: begin
				end
			endcase
			if (state_q == sat_pkg::ST_DONE && load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			sat_pkg::ST_IDLE: begin
				if (req_fire) begin
					act_q        <= act_in;
					q_q          <= (act_in == sat_pkg::ACT_V2O) ? req.virt_addr
						: req.file_offset;
					res_status_q <= sat_pkg::STAT_MISS;
					res_addr_q   <= '0;
					res_foff_q   <= '0;
					res_fva_q    <= '0;
					res_fperm_q  <= '0;
					unique case (act_in)
						sat_pkg::ACT_ADD: begin
							res_status_q <= full ? sat_pkg::STAT_FULL : sat_pkg::STAT_OK;
						end
						sat_pkg::ACT_V2O,
						sat_pkg::ACT_O2V: res_addr_q <= sat_pkg::ALL_ONES;
						sat_pkg::ACT_LOOKUP: begin
							res_foff_q  <= sat_pkg::ALL_ONES;
							res_fva_q   <= sat_pkg::ALL_ONES;
							res_fperm_q <= sat_pkg::PERM_NONE;
						end
						default: begin
						end
					endcase
				end
			end
			// base compare, offset into the section and section end
			sat_pkg::ST_EVAL: begin
				ent_q  <= rd_ent;
				diff_q <= diff_w[sat_pkg::ADDR_W-1:0];
				ge_q   <= !diff_w[sat_pkg::ADDR_W];
				lim_q  <= base + size;
			end
			sat_pkg::ST_CMP: begin
				if (hit && is_lookup) begin
					res_status_q <= sat_pkg::STAT_OK;
					res_foff_q   <= ent_q.off;
					res_fva_q    <= ent_q.va;
					res_fperm_q  <= ent_q.perms;
				end
			end
			// translated address: offset into the section plus the other base
			sat_pkg::ST_FIN: begin
				res_status_q <= sat_pkg::STAT_OK;
				res_addr_q   <= diff_q + (is_v2o ? ent_q.off : ent_q.va);
			end
			sat_pkg::ST_MV_RD: begin
				if (!more) begin
					res_status_q <= sat_pkg::STAT_OK;
				end
			end
			sat_pkg::ST_DONE: begin
				if (load_out) begin
					out_status_q <= res_status_q;
					out_addr_q   <= res_addr_q;
					out_foff_q   <= res_foff_q;
					out_fva_q    <= res_fva_q;
					out_fperm_q  <= res_fperm_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_addr  = out_addr_q;
	assign rsp.found_offset = out_foff_q;
	assign rsp.found_vaddr  = out_fva_q;
	assign rsp.found_perms  = out_fperm_q;

	// table never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SECTIONS))
		else $error("entry count above capacity");

	// an add into a table with room grows it by one
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && act_in == sat_pkg::ACT_ADD && !full)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("add did not grow the table");

	// the scan pointer stays inside the filled part of the table
	a_scan_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sat_pkg::ST_CMP) |-> ptr_q < count_q)
		else $error("scan pointer beyond entry count");

endmodule
